// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the iBUS/SBUS frame parser.
// No dependencies; simulation builds define the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ISFP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ISFP_NEVER(lbl, clk, rstn, cond, msg) \
	`ISFP_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define ISFP_ASSERT(lbl, clk, rstn, prop, msg)
`define ISFP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- hdl/isfp_pkg.sv -----
// Types and constants of the iBUS/SBUS frame parser.
// No dependencies; isfp_front, isfp_queue, isfp_back and the top module import it.
`timescale 1ns / 1ps
package isfp_pkg;
	localparam logic [5:0]  IBUS_SIZE   = 6'd32;
	localparam logic [5:0]  SBUS_SIZE   = 6'd25;
	localparam logic [7:0]  IBUS_HEAD   = 8'h20;
	localparam logic [7:0]  IBUS_HEAD2  = 8'h40;
	localparam logic [7:0]  SBUS_HEAD   = 8'h0F;
	localparam logic [15:0] CK_BASE     = 16'hFFFF;
	localparam logic [7:0]  END_A       = 8'h00;
	localparam logic [7:0]  END_B       = 8'h04;
	localparam logic [7:0]  END_C       = 8'h14;
	localparam logic [7:0]  END_D       = 8'h24;
	localparam logic [7:0]  END_E       = 8'h34;
	localparam int          LOST_BIT    = 2;
	localparam int          FS_BIT      = 3;
	localparam logic [10:0] SBUS_MID    = 11'd172;
	localparam logic [10:0] SBUS_ROUND  = 11'd819;
	localparam logic [10:0] SBUS_DIV    = 11'd1639;
	localparam logic [15:0] US_BASE     = 16'd1000;
	localparam logic [9:0]  US_SCALE    = 10'd1000;
	// floor(2^32 / 1639)
	localparam logic [21:0] DIV_RECIP   = 22'd2620480;
	localparam logic [3:0]  IBUS_LAST   = 4'd13;
	localparam logic [3:0]  SBUS_LAST   = 4'd15;

	localparam logic [1:0] REG_PROTOCOL = 2'd0;
	localparam logic [1:0] REG_CH_MIN   = 2'd1;
	localparam logic [1:0] REG_CH_MAX   = 2'd2;
	localparam logic [1:0] REG_GAP      = 2'd3;

	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_LOST     = 2'd2;
	localparam logic [1:0] ST_FAILSAFE = 2'd3;

	typedef struct packed {
		logic [15:0] raw;
		logic        last;
		logic        sbus;
		logic        lost;
		logic        fs;
		logic [31:0] time_ms;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage

// ----- hdl/isfp_in_if.sv -----
// Byte input channel of the frame parser.
// Depends on nothing.
`timescale 1ns / 1ps
interface isfp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [31:0] time_ms;
	modport source (output valid, data_byte, time_ms, input ready);
	modport sink (input valid, data_byte, time_ms, output ready);
endinterface

// ----- hdl/isfp_out_if.sv -----
// Channel result output of the frame parser.
// Depends on nothing.
`timescale 1ns / 1ps
interface isfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        lost_flag;
	logic        failsafe_flag;
	logic [31:0] frame_time_ms;
	logic        last_of_frame;
	modport source (output valid, status, channel_index, channel_value, lost_flag,
		failsafe_flag, frame_time_ms, last_of_frame, input ready);
	modport sink (input valid, status, channel_index, channel_value, lost_flag,
		failsafe_flag, frame_time_ms, last_of_frame, output ready);
endinterface

// ----- hdl/isfp_cfg_if.sv -----
// Configuration write channel of the frame parser.
// Depends on nothing.
`timescale 1ns / 1ps
interface isfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/isfp_front.sv -----
// Front end: byte intake, frame assembly, checksum/end check, resync, channel unpacking.
// Depends on isfp_pkg and isfp_in_if.
`timescale 1ns / 1ps
module isfp_front import isfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	isfp_in_if.sink     rx,
	input  logic        protocol,
	input  logic [15:0] gap_limit_ms,
	output logic        push,
	output qent_t       push_data,
	input  qstat_t      qstat
);
	localparam logic [2:0] FS_IDLE    = 3'd0;
	localparam logic [2:0] FS_SUM     = 3'd1;
	localparam logic [2:0] FS_CMP     = 3'd2;
	localparam logic [2:0] FS_RESYNC  = 3'd3;
	localparam logic [2:0] FS_EXTRACT = 3'd4;

	logic [2:0]  state_q;
	logic [7:0]  buf_q [32];
	logic [5:0]  fill_q;
	logic [31:0] prev_q;
	logic        seen_q;
	logic        proto_q;
	logic [31:0] time_q;
	logic        lost_q;
	logic        fs_q;
	logic [15:0] sum_q;
	logic [4:0]  cnt_q;
	logic [23:0] acc_q;
	logic [4:0]  nbits_q;
	logic [3:0]  chn_q;

	logic        acc_in;
	logic        gap_hit;
	logic [5:0]  size;
	logic [5:0]  f0;
	logic [5:0]  f;
	logic [7:0]  head;
	logic        wr_en;
	logic [4:0]  wr_idx;
	logic [5:0]  fill_nx;
	logic        done;
	logic        end_ok;
	logic        ck_good;
	logic [5:0]  kept_n;
	logic        rs_match;
	logic [7:0]  feed;
	logic [23:0] comb;
	logic [4:0]  tot;
	logic [4:0]  cw;
	logic        pop_now;
	logic        ext_go;
	logic [4:0]  nbytes_m1;

	assign rx.ready = (state_q == FS_IDLE);
	assign acc_in   = rx.valid && rx.ready;

	// Classify the incoming byte against the partial frame
	always_comb begin
		gap_hit = (fill_q != 6'd0) && seen_q &&
			((rx.time_ms - prev_q) >= {16'd0, gap_limit_ms});
		size    = protocol ? SBUS_SIZE : IBUS_SIZE;
		head    = protocol ? SBUS_HEAD : IBUS_HEAD;
		f0      = gap_hit ? 6'd0 : fill_q;
		f       = (f0 >= size) ? 6'd0 : f0;
		wr_en   = 1'b0;
		wr_idx  = 5'd0;
		fill_nx = 6'd0;
		done    = 1'b0;
		if (f == 6'd0) begin
			wr_en   = (rx.data_byte == head);
			fill_nx = wr_en ? 6'd1 : 6'd0;
		end else if (!protocol && f == 6'd1) begin
			if (rx.data_byte == IBUS_HEAD2) begin
				wr_en   = 1'b1;
				wr_idx  = 5'd1;
				fill_nx = 6'd2;
			end else if (rx.data_byte == IBUS_HEAD) begin
				wr_en   = 1'b1;
				fill_nx = 6'd1;
			end
		end else begin
			wr_en   = 1'b1;
			wr_idx  = f[4:0];
			fill_nx = f + 6'd1;
			done    = (fill_nx == size);
		end
		end_ok = rx.data_byte inside {END_A, END_B, END_C, END_D, END_E};
	end

	// Checksum compare and resync match
	always_comb begin
		ck_good = ({buf_q[31], buf_q[30]} == (CK_BASE - sum_q));
		kept_n  = fill_q - 6'd1;
		if (proto_q) begin
			rs_match = (buf_q[1] == SBUS_HEAD);
		end else begin
			rs_match = (buf_q[1] == IBUS_HEAD) && ((kept_n < 6'd2) || (buf_q[2] == IBUS_HEAD2));
		end
	end

	// Channel unpacking, one frame byte per step
	always_comb begin
		feed      = proto_q ? buf_q[1] : buf_q[2];
		comb      = acc_q | ({16'd0, feed} << nbits_q);
		tot       = nbits_q + 5'd8;
		cw        = proto_q ? 5'd11 : 5'd16;
		pop_now   = (tot >= cw);
		ext_go    = (state_q == FS_EXTRACT) && (!pop_now || !qstat.full);
		nbytes_m1 = proto_q ? 5'd21 : 5'd27;
		push      = ext_go && pop_now;
		push_data.raw     = proto_q ? {5'd0, comb[10:0]} : comb[15:0];
		push_data.last    = (chn_q == (proto_q ? SBUS_LAST : IBUS_LAST));
		push_data.sbus    = proto_q;
		push_data.lost    = lost_q;
		push_data.fs      = fs_q;
		push_data.time_ms = time_q;
	end

	// Frame buffer: write, rotate for the checksum, shift for resync and unpacking
	always_ff @(posedge clk) begin
		case (state_q)
			FS_IDLE: begin
				if (acc_in && wr_en) begin
					buf_q[wr_idx] <= rx.data_byte;
				end
			end
			FS_SUM: begin
				for (int i = 0; i < 31; i++) begin
					buf_q[i] <= buf_q[i + 1];
				end
				buf_q[31] <= buf_q[0];
			end
			FS_RESYNC: begin
				for (int i = 0; i < 31; i++) begin
					buf_q[i] <= buf_q[i + 1];
				end
			end
			FS_EXTRACT: begin
				if (ext_go) begin
					for (int i = 0; i < 31; i++) begin
						buf_q[i] <= buf_q[i + 1];
					end
				end
			end
			default: ;
		endcase
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			fill_q  <= 6'd0;
			prev_q  <= 32'd0;
			seen_q  <= 1'b0;
			proto_q <= 1'b0;
			time_q  <= 32'd0;
			lost_q  <= 1'b0;
			fs_q    <= 1'b0;
			sum_q   <= 16'd0;
			cnt_q   <= 5'd0;
			acc_q   <= 24'd0;
			nbits_q <= 5'd0;
			chn_q   <= 4'd0;
		end else begin
			case (state_q)
				FS_IDLE: begin
					if (acc_in) begin
						prev_q  <= rx.time_ms;
						seen_q  <= 1'b1;
						fill_q  <= fill_nx;
						proto_q <= protocol;
						time_q  <= rx.time_ms;
						sum_q   <= 16'd0;
						cnt_q   <= 5'd0;
						acc_q   <= 24'd0;
						nbits_q <= 5'd0;
						chn_q   <= 4'd0;
						lost_q  <= 1'b0;
						fs_q    <= 1'b0;
						if (done) begin
							if (!protocol) begin
								state_q <= FS_SUM;
							end else if (end_ok) begin
								lost_q  <= buf_q[23][LOST_BIT];
								fs_q    <= buf_q[23][FS_BIT];
								state_q <= FS_EXTRACT;
							end else begin
								state_q <= FS_RESYNC;
							end
						end
					end
				end
				FS_SUM: begin
					if (cnt_q < 5'd30) begin
						sum_q <= sum_q + {8'd0, buf_q[0]};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= FS_CMP;
					end
				end
				FS_CMP: begin
					cnt_q   <= 5'd0;
					state_q <= ck_good ? FS_EXTRACT : FS_RESYNC;
				end
				FS_RESYNC: begin
					fill_q <= kept_n;
					if (kept_n == 6'd0 || rs_match) begin
						state_q <= FS_IDLE;
					end
				end
				FS_EXTRACT: begin
					if (ext_go) begin
						if (pop_now) begin
							acc_q   <= comb >> cw;
							nbits_q <= tot - cw;
							chn_q   <= chn_q + 4'd1;
						end else begin
							acc_q   <= comb;
							nbits_q <= tot;
						end
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == nbytes_m1) begin
							fill_q  <= 6'd0;
							state_q <= FS_IDLE;
						end
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/isfp_queue.sv -----
// Short channel queue between front end and back end.
// Depends on isfp_pkg.
`timescale 1ns / 1ps
module isfp_queue import isfp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  push_data,
	input  logic   pop,
	output qent_t  head,
	output qstat_t qstat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	qent_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign qstat.full  = (cnt_q == FULL_CNT);
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// ----- hdl/isfp_back.sv -----
// Back end: SBUS microsecond scaling, range check, channel result emission.
// Depends on isfp_pkg and isfp_out_if.
`timescale 1ns / 1ps
module isfp_back import isfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qent_t       head,
	input  qstat_t      qstat,
	output logic        pop,
	input  logic [15:0] rng_lo,
	input  logic [15:0] rng_hi,
	isfp_out_if.source  res
);
	localparam logic [2:0] BS_IN  = 3'd0;
	localparam logic [2:0] BS_MUL = 3'd1;
	localparam logic [2:0] BS_REM = 3'd2;
	localparam logic [2:0] BS_COR = 3'd3;
	localparam logic [2:0] BS_WR  = 3'd4;
	localparam logic [2:0] BS_OUT = 3'd5;

	logic [2:0]  st_q;
	qent_t       ent_q;
	logic [20:0] x_q;
	logic        neg_q;
	logic [10:0] q0_q;
	logic [20:0] rem_q;
	logic [15:0] val_q;
	logic [15:0] chan_q [16];
	logic [3:0]  idx_q;
	logic [3:0]  oidx_q;
	logic [3:0]  last_idx_q;
	logic        ok_q;
	logic        m_lost_q;
	logic        m_fs_q;
	logic [31:0] m_time_q;
	logic        o_vld_q;
	logic [1:0]  o_status_q;
	logic [3:0]  o_idx_q;
	logic [15:0] o_val_q;
	logic        o_lost_q;
	logic        o_fs_q;
	logic [31:0] o_time_q;
	logic        o_last_q;

	logic [10:0] raw11;
	logic [10:0] offs;
	logic [42:0] prod;
	logic [21:0] back_mul;
	logic [10:0] mag;
	logic        in_rng;
	logic        load;
	logic [1:0]  fr_status;

	assign pop = (st_q == BS_IN) && !qstat.empty;

	// Scaling datapath pieces
	always_comb begin
		raw11     = head.raw[10:0];
		offs      = (raw11 >= SBUS_MID) ? (raw11 - SBUS_MID) : (SBUS_MID - raw11);
		prod      = 43'(x_q) * 43'(DIV_RECIP);
		back_mul  = 22'(q0_q) * 22'(SBUS_DIV);
		mag       = (rem_q >= 21'(SBUS_DIV)) ? (q0_q + 11'd1) : q0_q;
		in_rng    = (val_q >= rng_lo) && (val_q <= rng_hi);
		load      = !o_vld_q || res.ready;
		if (m_fs_q) begin
			fr_status = ST_FAILSAFE;
		end else if (m_lost_q) begin
			fr_status = ST_LOST;
		end else begin
			fr_status = ok_q ? ST_VALID : ST_RANGE;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			BS_IN: begin
				if (pop) begin
					ent_q <= head;
					x_q   <= 21'(offs) * 21'(US_SCALE) + 21'(SBUS_ROUND);
					neg_q <= (raw11 < SBUS_MID);
					val_q <= head.raw;
				end
			end
			BS_MUL: q0_q <= prod[42:32];
			BS_REM: rem_q <= x_q - 21'(back_mul);
			BS_COR: val_q <= neg_q ? (US_BASE - 16'(mag)) : (US_BASE + 16'(mag));
			BS_WR: chan_q[idx_q] <= val_q;
			default: ;
		endcase
		if (load && st_q == BS_OUT) begin
			o_status_q <= fr_status;
			o_idx_q    <= oidx_q;
			o_val_q    <= chan_q[oidx_q];
			o_lost_q   <= m_lost_q;
			o_fs_q     <= m_fs_q;
			o_time_q   <= m_time_q;
			o_last_q   <= (oidx_q == last_idx_q);
		end
	end

	// Sequencer: convert, collect, then emit a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BS_IN;
			idx_q      <= 4'd0;
			oidx_q     <= 4'd0;
			last_idx_q <= 4'd0;
			ok_q       <= 1'b1;
			m_lost_q   <= 1'b0;
			m_fs_q     <= 1'b0;
			m_time_q   <= 32'd0;
			o_vld_q    <= 1'b0;
		end else begin
			if (load) begin
				o_vld_q <= (st_q == BS_OUT);
			end
			case (st_q)
				BS_IN: begin
					if (pop) begin
						st_q <= head.sbus ? BS_MUL : BS_WR;
					end
				end
				BS_MUL: st_q <= BS_REM;
				BS_REM: st_q <= BS_COR;
				BS_COR: st_q <= BS_WR;
				BS_WR: begin
					ok_q <= ok_q && in_rng;
					if (ent_q.last) begin
						last_idx_q <= idx_q;
						m_lost_q   <= ent_q.lost;
						m_fs_q     <= ent_q.fs;
						m_time_q   <= ent_q.time_ms;
						oidx_q     <= 4'd0;
						st_q       <= BS_OUT;
					end else begin
						idx_q <= idx_q + 4'd1;
						st_q  <= BS_IN;
					end
				end
				BS_OUT: begin
					if (load) begin
						if (oidx_q == last_idx_q) begin
							idx_q <= 4'd0;
							ok_q  <= 1'b1;
							st_q  <= BS_IN;
						end else begin
							oidx_q <= oidx_q + 4'd1;
						end
					end
				end
				default: st_q <= BS_IN;
			endcase
		end
	end

	assign res.valid         = o_vld_q;
	assign res.status        = o_status_q;
	assign res.channel_index = o_idx_q;
	assign res.channel_value = o_val_q;
	assign res.lost_flag     = o_lost_q;
	assign res.failsafe_flag = o_fs_q;
	assign res.frame_time_ms = o_time_q;
	assign res.last_of_frame = o_last_q;
endmodule

// ----- hdl/ibus_sbus_frame_parser_top.sv -----
// A finished iBUS frame goes through checksum rotation and compare, then its 28 channel bytes
// are unpacked; SBUS goes straight to unpacking its 22. Unpacking stalls while the queue
// is full. Throughput: one byte per cycle while no frame is checked, resynced or unpacked;
// the back end takes each iBUS channel through intake and write, each SBUS channel also through
// multiply, remainder and correction (scaling multiplier chain), then emits one result per cycle
// while res.ready allows. Reset: asynchronous, active low, no clear pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ibus_sbus_frame_parser_top import isfp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	isfp_in_if.sink     rx,
	isfp_out_if.source  res,
	isfp_cfg_if.sink    cfg
);
	logic        protocol_q;
	logic [15:0] ch_min_q;
	logic [15:0] ch_max_q;
	logic [15:0] gap_q;
	logic        push;
	qent_t       push_data;
	logic        pop;
	qent_t       head;
	qstat_t      qstat;
	logic        last_ok;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= 1'b0;
			ch_min_q   <= 16'd0;
			ch_max_q   <= 16'hFFFF;
			gap_q      <= 16'd3;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PROTOCOL: protocol_q <= cfg.data[0];
				REG_CH_MIN:   ch_min_q   <= cfg.data;
				REG_CH_MAX:   ch_max_q   <= cfg.data;
				REG_GAP:      gap_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	isfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx),
		.protocol     (protocol_q),
		.gap_limit_ms (gap_q),
		.push         (push),
		.push_data    (push_data),
		.qstat        (qstat)
	);

	isfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	isfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rng_lo (ch_min_q),
		.rng_hi (ch_max_q),
		.res    (res)
	);

	// Last result of a frame carries the final channel of either format
	assign last_ok = (res.channel_index == IBUS_LAST) || (res.channel_index == SBUS_LAST);

	`ISFP_NEVER(a_queue_ovf, clk, arst_n, push && qstat.full, "channel queue overflow")
	`ISFP_ASSERT(a_last_idx, clk, arst_n, (res.valid && res.last_of_frame) |-> last_ok, "bad last")
	`ISFP_ASSERT(a_fs_status, clk, arst_n, (res.valid && res.failsafe_flag) |-> (res.status == ST_FAILSAFE), "failsafe frame without failsafe status")
endmodule
